@@ rtl/mcrs_pkg.sv @@
package mcrs_pkg;

	localparam int HALF_SIZE_DEF = 256;
	localparam int MAX_LEN_DEF   = 32;

	localparam logic [7:0] CHK_GOOD = 8'hff;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_BAD   = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_READ  = 1'b1
	} mode_t;

	typedef enum logic {
		SRC_PRIMARY = 1'b0,
		SRC_BACKUP  = 1'b1
	} src_t;

endpackage

@@ rtl/mcrs_ram.sv @@
module mcrs_ram #(
	parameter int DEPTH = mcrs_pkg::HALF_SIZE_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ rtl/mirrored_checksum_record_store_unit.sv @@
// channel | dir | tdata (low bit up)                          | tuser      | tlast
// s_*     | in  | offset[7:0] length[13:8] data_byte[21:14]   | mode       | last
// m_*     | out | read_byte[7:0]                              | status     | final_res
//
// After reset a clearing pass zeroes both halves with s_tready low.
// Write beat with last: byte, check byte, then status; a range error gives the status only.
// Read: S_RSUM sums both copies and their check bytes in parallel, then each returned byte
// passes S_ERD (memory read) and S_EWAIT (output register); a repair adds a check-byte pass.
// A stalled output holds S_STAT and S_EWAIT; no new beat is taken until an operation ends.
module mirrored_checksum_record_store_unit #(
	parameter int HALF_SIZE = mcrs_pkg::HALF_SIZE_DEF,
	parameter int MAX_LEN   = mcrs_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // offset[7:0], length[13:8], data_byte[21:14], zero pad
	input  logic [0:0]  s_tuser,  // mode[0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // read_byte[7:0]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast
);

	localparam int AW = $clog2(HALF_SIZE);
	localparam int SW = (AW + 1 > 9) ? AW + 1 : 9;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_WCHK  = 9'b000000100,
		S_STAT  = 9'b000001000,
		S_RSUM  = 9'b000010000,
		S_RCHK  = 9'b000100000,
		S_ERD   = 9'b001000000,
		S_EWAIT = 9'b010000000,
		S_SPARE = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [5:0]        wpos_q;
	logic [7:0]        wsum_q;
	logic              wrej_q;
	logic [7:0]        chk_q;
	logic [AW-1:0]     chk_addr_q;
	mcrs_pkg::status_t st_q;
	logic [7:0]        off_q;
	logic [5:0]        len_q;
	logic [5:0]        cnt_q;
	logic [7:0]        psum_q;
	logic [7:0]        bsum_q;
	logic              pend_q;
	mcrs_pkg::src_t    src_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic [1:0]        out_st_q;
	logic              out_last_q;

	logic [7:0]    in_offset;
	logic [5:0]    in_length;
	logic [7:0]    in_data;
	logic          in_acc;
	logic          in_fits;
	logic [SW-1:0] end_sum;
	logic          w_fit;
	logic          w_store;
	logic          w_rej;
	logic [SW-1:0] w_addr_sum;
	logic [AW-1:0] w_addr;
	logic [7:0]    wsum_n;
	logic [5:0]    wpos_n;
	logic [SW-1:0] rd_addr_sum;
	logic [AW-1:0] rd_addr;
	logic          out_free;
	logic          out_load;
	logic          ew_fire;
	logic          ew_emit;
	logic          ew_final;
	logic [7:0]    tot_p;
	logic [7:0]    tot_b;
	logic [7:0]    emit_byte;

	logic          p_we;
	logic [AW-1:0] p_waddr;
	logic [7:0]    p_wdata;
	logic          b_we;
	logic [AW-1:0] b_waddr;
	logic [7:0]    b_wdata;
	logic          rd_en;
	logic [7:0]    p_rdata;
	logic [7:0]    b_rdata;

	assign in_offset = s_tdata[7:0];
	assign in_length = s_tdata[13:8];
	assign in_data   = s_tdata[21:14];

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign end_sum = SW'(in_offset) + SW'(in_length) + SW'(1);
	assign in_fits = (in_length != 6'd0) && (in_length <= 6'(MAX_LEN))
		&& (end_sum <= SW'(HALF_SIZE));

	assign w_fit      = in_fits && (wpos_q < in_length);
	assign w_store    = !wrej_q && w_fit;
	assign w_rej      = wrej_q || !w_fit;
	assign w_addr_sum = SW'(in_offset) + SW'(wpos_q);
	assign w_addr     = w_addr_sum[AW-1:0];
	assign wsum_n     = wsum_q + in_data;
	assign wpos_n     = wpos_q + 6'd1;

	assign rd_addr_sum = SW'(off_q) + SW'(cnt_q);
	assign rd_addr     = rd_addr_sum[AW-1:0];

	assign out_free  = !out_valid_q || m_tready;
	assign emit_byte = (src_q == mcrs_pkg::SRC_BACKUP) ? b_rdata : p_rdata;
	assign ew_emit   = (cnt_q != len_q);
	assign ew_fire   = !ew_emit || out_free;
	assign ew_final  = (cnt_q == 6'(len_q - 6'd1));
	assign out_load  = ((state_q == S_STAT) && out_free)
		|| ((state_q == S_EWAIT) && ew_fire && ew_emit);

	assign tot_p = psum_q + p_rdata;
	assign tot_b = bsum_q + b_rdata;

	assign rd_en = (state_q == S_RSUM) || (state_q == S_ERD);

	always_comb begin
		p_we    = 1'b0;
		p_waddr = w_addr;
		p_wdata = in_data;
		b_we    = 1'b0;
		b_waddr = w_addr;
		b_wdata = in_data;
		case (state_q)
			S_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = 8'd0;
				b_we    = 1'b1;
				b_waddr = clr_q;
				b_wdata = 8'd0;
			end
			S_IDLE: begin
				p_we = in_acc && (s_tuser[0] == mcrs_pkg::MODE_WRITE) && w_store;
				b_we = p_we;
			end
			S_WCHK: begin
				p_we    = 1'b1;
				p_waddr = chk_addr_q;
				p_wdata = chk_q;
				b_we    = 1'b1;
				b_waddr = chk_addr_q;
				b_wdata = chk_q;
			end
			S_EWAIT: begin
				// repair: backup byte copied over the primary, check byte included
				p_we    = (src_q == mcrs_pkg::SRC_BACKUP) && ew_fire;
				p_waddr = rd_addr;
				p_wdata = b_rdata;
			end
			default: begin
				p_we = 1'b0;
				b_we = 1'b0;
			end
		endcase
	end

	mcrs_ram #(.DEPTH(HALF_SIZE), .AW(AW)) u_primary (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (p_rdata)
	);

	mcrs_ram #(.DEPTH(HALF_SIZE), .AW(AW)) u_backup (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			wpos_q      <= 6'd0;
			wsum_q      <= 8'd0;
			wrej_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q      <= (state_q == S_RSUM);
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(HALF_SIZE - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc && s_tuser[0] == mcrs_pkg::MODE_WRITE) begin
						if (!s_tlast) begin
							wrej_q <= w_rej;
							if (w_store) begin
								wsum_q <= wsum_n;
								wpos_q <= wpos_n;
							end
						end else begin
							wpos_q <= 6'd0;
							wsum_q <= 8'd0;
							wrej_q <= 1'b0;
							if (w_rej) begin
								st_q    <= mcrs_pkg::STATUS_RANGE;
								state_q <= S_STAT;
							end else begin
								chk_q      <= mcrs_pkg::CHK_GOOD - wsum_n;
								chk_addr_q <= w_addr + AW'(1);
								st_q       <= mcrs_pkg::STATUS_OK;
								state_q    <= S_WCHK;
							end
						end
					end else if (in_acc) begin
						if (!in_fits) begin
							st_q    <= mcrs_pkg::STATUS_RANGE;
							state_q <= S_STAT;
						end else begin
							off_q   <= in_offset;
							len_q   <= in_length;
							cnt_q   <= 6'd0;
							psum_q  <= 8'd0;
							bsum_q  <= 8'd0;
							state_q <= S_RSUM;
						end
					end
				end
				S_WCHK: state_q <= S_STAT;
				S_STAT: begin
					if (out_free) begin
						out_data_q  <= 8'd0;
						out_st_q    <= st_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RSUM: begin
					if (pend_q) begin
						psum_q <= tot_p;
						bsum_q <= tot_b;
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == len_q)
						state_q <= S_RCHK;
				end
				S_RCHK: begin
					// last check byte lands this cycle, totals are formed on the fly
					cnt_q <= 6'd0;
					if (tot_p == mcrs_pkg::CHK_GOOD) begin
						src_q   <= mcrs_pkg::SRC_PRIMARY;
						state_q <= S_ERD;
					end else if (tot_b == mcrs_pkg::CHK_GOOD) begin
						src_q   <= mcrs_pkg::SRC_BACKUP;
						state_q <= S_ERD;
					end else begin
						st_q    <= mcrs_pkg::STATUS_BAD;
						state_q <= S_STAT;
					end
				end
				S_ERD: state_q <= S_EWAIT;
				S_EWAIT: begin
					if (ew_fire) begin
						if (ew_emit) begin
							out_data_q  <= emit_byte;
							out_st_q    <= mcrs_pkg::STATUS_OK;
							out_last_q  <= ew_final;
						end
						if (!ew_emit || (ew_final && src_q == mcrs_pkg::SRC_PRIMARY)) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + 6'd1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_status_item_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != mcrs_pkg::STATUS_OK) |-> (m_tlast && m_tdata == 8'd0))
		else $error("status beat not marked final or carries data");

	a_wpos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= 6'(MAX_LEN))
		else $error("write position beyond maximum record length");

	a_check_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RCHK) |-> (pend_q && $past(state_q) == S_RSUM))
		else $error("checksum decision without final summed byte");

	a_repair_from_backup: assert property (@(posedge clk) disable iff (!arst_n)
		(p_we && state_q == S_EWAIT) |-> (src_q == mcrs_pkg::SRC_BACKUP))
		else $error("primary rewritten while reading a good primary");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERD || state_q == S_EWAIT) |-> (cnt_q <= len_q))
		else $error("emit index beyond record length");
`endif

endmodule
